/* hw/rtl/i2cmts_pkg.sv */
package i2cmts_pkg;

   // Buffer depths and the address widths that follow from them.
   localparam int RegBytes  = 4;
   localparam int DataBytes = 16;
   localparam int RegAw     = $clog2(RegBytes);
   localparam int DataAw    = $clog2(DataBytes);

   // Count limits in the widths of the start fields.
   localparam logic [2:0] RegCntMax  = 3'(RegBytes);
   localparam logic [4:0] DataCntMax = 5'(DataBytes);

   // Stream widths.
   localparam int ReqDataW = 40;
   localparam int RspDataW = 24;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_START = 2'd1,
      OP_EVENT = 2'd2,
      OP_NOP   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      PH_DONE       = 3'd0,
      PH_WAIT_START = 3'd1,
      PH_SENDING    = 3'd2,
      PH_RX_ACK     = 3'd3,
      PH_RX_DATA    = 3'd4,
      PH_WAIT_STOP  = 3'd5,
      PH_ERROR      = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_START   = 3'd1,
      CMD_RESTART = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_TX      = 3'd4,
      CMD_RX      = 3'd5,
      CMD_ACK     = 3'd6,
      CMD_NACK    = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_ONGOING = 2'd1,
      ST_ERROR   = 2'd2
   } status_type;

   // Buffer select codes.
   localparam logic SEL_REG  = 1'b0;
   localparam logic SEL_DATA = 1'b1;

   // Fields of one request item, from the highest tdata bit down.
   typedef struct packed {
      logic [6:0] pad;
      logic       rx_full;
      logic       nack_seen;
      logic       stop_seen;
      logic       start_seen;
      logic       read_flag;
      logic [4:0] data_byte_count;
      logic [2:0] reg_byte_count;
      logic [6:0] slave_addr;
      logic [7:0] load_value;
      logic [3:0] load_index;
      logic       buffer_select;
   } req_item_type;

endpackage

/* hw/rtl/i2c_master_transaction_sequencer_core.sv */
// I2C master transaction sequencer.
// Request channel (req_*): each item is a buffer load, a start request, a
// bus controller event or a no-op; the operation travels in req_tuser.
// Every request item gives exactly one response item (rsp_*) carrying the
// bus command to issue in rsp_tuser and the transmit byte, received byte
// and status in rsp_tdata.
// The register-address and data buffers sit in synchronous memories that
// are read at the current cursors as an item is accepted. The accepted item
// is held in its stage and then applied: state and buffer writes are
// committed and the response is registered, which raises rsp_tvalid. A new
// item is not taken until the held one has been applied.
// The response register lets a new item be accepted while a response waits;
// if the receiver stalls, the held item waits in its stage and req_tready
// stays low until the response register frees.
// Synchronous reset returns the sequencer to done with cleared counters.
// Buffer contents are not reset; entries must be loaded before they are sent.
module i2c_master_transaction_sequencer_core
   import i2cmts_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   // Fields from bit 0: buffer_select, load_index[3:0], load_value[7:0],
   // slave_addr[6:0], reg_byte_count[2:0], data_byte_count[4:0], read_flag,
   // start_seen, stop_seen, nack_seen, rx_full, zero padding.
   input  logic [ReqDataW-1:0] req_tdata,
   // Fields from bit 0: operation[1:0].
   input  logic [1:0]          req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // Fields from bit 0: tx_byte[7:0], rx_valid, rx_byte_out[7:0],
   // rx_position[3:0], status[1:0], zero padding.
   output logic [RspDataW-1:0] rsp_tdata,
   // Fields from bit 0: bus_command[2:0].
   output logic [2:0]          rsp_tuser
);

   // Buffer memories.
   logic [7:0] reg_mem  [RegBytes];
   logic [7:0] data_mem [DataBytes];

   // Held item stage.
   logic         stage_ff;
   logic         stage_in;
   op_type       op_ff;
   req_item_type item_ff;
   logic [7:0]   reg_rd_ff;
   logic [7:0]   data_rd_ff;

   // Transaction state.
   phase_type         phase_ff, phase_in;
   logic [6:0]        target_ff, target_in;
   logic [2:0]        reg_rem_ff, reg_rem_in;
   logic [4:0]        data_rem_ff, data_rem_in;
   logic [RegAw-1:0]  reg_cur_ff, reg_cur_in;
   logic [DataAw-1:0] data_cur_ff, data_cur_in;
   logic              is_read_ff, is_read_in;

   // Response register.
   logic       rsp_valid_ff;
   cmd_type    cmd_ff, cmd_in;
   logic [7:0] txb_ff, txb_in;
   logic       rxv_ff, rxv_in;
   logic [7:0] rxb_ff, rxb_in;
   logic [3:0] rxp_ff, rxp_in;
   status_type status_ff, status_in;

   // Memory write ports.
   logic              reg_we;
   logic [RegAw-1:0]  reg_waddr;
   logic              data_we;
   logic [DataAw-1:0] data_waddr;
   logic [7:0]        data_wdata;

   logic accept;
   logic commit;

   assign req_tready = !stage_ff;
   assign accept     = req_tvalid && req_tready;
   assign commit     = stage_ff && (!rsp_valid_ff || rsp_tready);

   // Item stage occupancy.
   always_comb begin
      stage_in = stage_ff;
      if (accept) begin
         stage_in = 1'b1;
      end else if (commit) begin
         stage_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= 1'b0;
      end else begin
         stage_ff <= stage_in;
      end
   end

   // Capture the item and read both buffers at the current cursors.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= op_type'(req_tuser);
         item_ff    <= req_item_type'(req_tdata);
         reg_rd_ff  <= reg_mem[reg_cur_ff];
         data_rd_ff <= data_mem[data_cur_ff];
      end
   end

   // Buffer writes happen in the commit cycle.
   always_ff @(posedge clock) begin
      if (reg_we) begin
         reg_mem[reg_waddr] <= item_ff.load_value;
      end
      if (data_we) begin
         data_mem[data_waddr] <= data_wdata;
      end
   end

   // Next phase.
   always_comb begin
      phase_in = phase_ff;
      if (op_ff == OP_START) begin
         if (phase_ff == PH_DONE) begin
            phase_in = PH_WAIT_START;
         end
      end else if (op_ff == OP_EVENT) begin
         case (phase_ff)
            PH_WAIT_START: begin
               if (item_ff.start_seen) begin
                  phase_in = (reg_rem_ff == 3'd0) ? PH_RX_ACK : PH_SENDING;
               end
            end
            PH_SENDING: begin
               if (item_ff.nack_seen) begin
                  phase_in = PH_ERROR;
               end else if (reg_rem_ff != 3'd0) begin
                  phase_in = PH_SENDING;
               end else if (is_read_ff) begin
                  phase_in = PH_WAIT_START;
               end else if (data_rem_ff == 5'd0) begin
                  phase_in = PH_WAIT_STOP;
               end
            end
            PH_RX_ACK: begin
               phase_in = (data_rem_ff != 5'd0) ? PH_RX_DATA : PH_WAIT_STOP;
            end
            PH_RX_DATA: begin
               if (item_ff.rx_full) begin
                  phase_in = PH_RX_ACK;
               end
            end
            PH_WAIT_STOP: begin
               if (item_ff.stop_seen) begin
                  phase_in = PH_DONE;
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // Commands, counters, buffer writes and response fields.
   always_comb begin
      cmd_in      = CMD_NONE;
      txb_in      = 8'd0;
      rxv_in      = 1'b0;
      rxb_in      = 8'd0;
      rxp_in      = 4'd0;
      target_in   = target_ff;
      reg_rem_in  = reg_rem_ff;
      data_rem_in = data_rem_ff;
      reg_cur_in  = reg_cur_ff;
      data_cur_in = data_cur_ff;
      is_read_in  = is_read_ff;
      reg_we      = 1'b0;
      reg_waddr   = item_ff.load_index[RegAw-1:0];
      data_we     = 1'b0;
      data_waddr  = item_ff.load_index[DataAw-1:0];
      data_wdata  = item_ff.load_value;

      case (op_ff)
         OP_LOAD: begin
            if (item_ff.buffer_select == SEL_REG) begin
               reg_we = 32'(item_ff.load_index) < RegBytes;
            end else begin
               data_we = 32'(item_ff.load_index) < DataBytes;
            end
         end
         OP_START: begin
            if (phase_ff == PH_DONE) begin
               target_in   = item_ff.slave_addr;
               reg_rem_in  = (item_ff.reg_byte_count > RegCntMax) ?
                             RegCntMax : item_ff.reg_byte_count;
               data_rem_in = (item_ff.data_byte_count > DataCntMax) ?
                             DataCntMax : item_ff.data_byte_count;
               is_read_in  = item_ff.read_flag;
               reg_cur_in  = '0;
               data_cur_in = '0;
               cmd_in      = CMD_START;
            end
         end
         OP_EVENT: begin
            case (phase_ff)
               PH_WAIT_START: begin
                  if (item_ff.start_seen) begin
                     // Address byte; the read bit is set when no register
                     // bytes remain.
                     cmd_in = CMD_TX;
                     txb_in = {target_ff, reg_rem_ff == 3'd0};
                  end
               end
               PH_SENDING: begin
                  if (item_ff.nack_seen) begin
                     cmd_in = CMD_NONE;
                  end else if (reg_rem_ff != 3'd0) begin
                     cmd_in     = CMD_TX;
                     txb_in     = reg_rd_ff;
                     reg_cur_in = reg_cur_ff + 1'b1;
                     reg_rem_in = reg_rem_ff - 3'd1;
                  end else if (is_read_ff) begin
                     cmd_in = CMD_RESTART;
                  end else if (data_rem_ff != 5'd0) begin
                     cmd_in      = CMD_TX;
                     txb_in      = data_rd_ff;
                     data_cur_in = data_cur_ff + 1'b1;
                     data_rem_in = data_rem_ff - 5'd1;
                  end else begin
                     cmd_in = CMD_STOP;
                  end
               end
               PH_RX_ACK: begin
                  cmd_in = (data_rem_ff != 5'd0) ? CMD_RX : CMD_STOP;
               end
               PH_RX_DATA: begin
                  if (item_ff.rx_full) begin
                     // Store the received byte and acknowledge all but the last.
                     data_we     = 1'b1;
                     data_waddr  = data_cur_ff;
                     rxv_in      = 1'b1;
                     rxb_in      = item_ff.load_value;
                     rxp_in      = 4'(data_cur_ff);
                     data_cur_in = data_cur_ff + 1'b1;
                     if (data_rem_ff != 5'd0) begin
                        data_rem_in = data_rem_ff - 5'd1;
                     end
                     cmd_in = (data_rem_in != 5'd0) ? CMD_ACK : CMD_NACK;
                  end
               end
               default: begin
                  cmd_in = CMD_NONE;
               end
            endcase
         end
         default: begin
            cmd_in = CMD_NONE;
         end
      endcase

      if (!commit) begin
         reg_we  = 1'b0;
         data_we = 1'b0;
      end

      // Status after the step.
      if (phase_in == PH_ERROR) begin
         status_in = ST_ERROR;
      end else if (phase_in != PH_DONE) begin
         status_in = ST_ONGOING;
      end else begin
         status_in = ST_DONE;
      end
   end

   // Transaction state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_DONE;
         target_ff   <= '0;
         reg_rem_ff  <= '0;
         data_rem_ff <= '0;
         reg_cur_ff  <= '0;
         data_cur_ff <= '0;
         is_read_ff  <= 1'b0;
      end else if (commit) begin
         phase_ff    <= phase_in;
         target_ff   <= target_in;
         reg_rem_ff  <= reg_rem_in;
         data_rem_ff <= data_rem_in;
         reg_cur_ff  <= reg_cur_in;
         data_cur_ff <= data_cur_in;
         is_read_ff  <= is_read_in;
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         cmd_ff    <= cmd_in;
         txb_ff    <= txb_in;
         rxv_ff    <= rxv_in;
         rxb_ff    <= rxb_in;
         rxp_ff    <= rxp_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = cmd_ff;
   assign rsp_tdata  = {1'b0, status_ff, rxp_ff, rxb_ff, rxv_ff, txb_ff};

   // The error phase is left only through reset.
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_ERROR |=> phase_ff == PH_ERROR)
      else $error("error phase was left without reset");

   // A received byte is always answered with an acknowledge or a not-acknowledge.
   a_rx_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rxv_ff |-> cmd_ff == CMD_ACK || cmd_ff == CMD_NACK)
      else $error("received byte without ack or nack command");

   // A transmit byte is only shown with a transmit command.
   a_txb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && cmd_ff != CMD_TX |-> txb_ff == 8'd0)
      else $error("transmit byte set without transmit command");

   // A held item is not dropped while the response register is blocked.
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      stage_ff && rsp_valid_ff && !rsp_tready |=> stage_ff)
      else $error("held item lost while response stalled");

   // State changes only when an item is applied.
   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !commit |=> $stable(phase_ff) && $stable(data_cur_ff))
      else $error("state changed without an applied item");

endmodule
